// ----- hdl/sbl_pkg.sv -----
package sbl_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int STATUS_W = 3;
   localparam int ENTRY_COUNT_W = 5;
   localparam int VALUE_W = 8;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DELETE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_REMOVED   = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CHK,
      S_DEL_RD,
      S_DEL_CHK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic ins_step;
      logic del_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic ins_more;
      logic del_last;
      logic slot_free;
   } sts_type;

endpackage

// ----- hdl/sbl_ctrl.sv -----
module sbl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_command,
   input  sbl_pkg::sts_type sts,
   output sbl_pkg::cmd_type cmd,
   output logic             req_stall
);

   sbl_pkg::state_type state_ff;
   sbl_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbl_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sbl_pkg::S_IDLE: begin
            if (req_valid) begin
               if (req_command == sbl_pkg::CMD_INSERT) begin
                  state_in = sts.full ? sbl_pkg::S_DONE : sbl_pkg::S_INS_RD;
               end else begin
                  state_in = sts.empty ? sbl_pkg::S_DONE : sbl_pkg::S_DEL_RD;
               end
            end
         end
         sbl_pkg::S_INS_RD:  state_in = sbl_pkg::S_INS_CHK;
         sbl_pkg::S_INS_CHK: state_in = sts.ins_more ? sbl_pkg::S_INS_RD : sbl_pkg::S_DONE;
         sbl_pkg::S_DEL_RD:  state_in = sbl_pkg::S_DEL_CHK;
         sbl_pkg::S_DEL_CHK: state_in = sts.del_last ? sbl_pkg::S_DONE : sbl_pkg::S_DEL_RD;
         sbl_pkg::S_DONE: begin
            if (sts.slot_free) begin
               state_in = sbl_pkg::S_IDLE;
            end
         end
         default: state_in = sbl_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         sbl_pkg::S_IDLE: begin
            req_stall = 1'b0;
            cmd.load = req_valid;
         end
         sbl_pkg::S_INS_CHK: cmd.ins_step = 1'b1;
         sbl_pkg::S_DEL_CHK: cmd.del_step = 1'b1;
         sbl_pkg::S_DONE:    cmd.emit = sts.slot_free;
         default: ;
      endcase
   end

endmodule

// ----- hdl/sbl_datapath.sv -----
module sbl_datapath #(
   parameter int CAPACITY = sbl_pkg::CAPACITY_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  sbl_pkg::cmd_type                   cmd,
   output sbl_pkg::sts_type                   sts,
   input  logic                               req_command,
   input  logic [sbl_pkg::VALUE_W-1:0]        req_item_value,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic [sbl_pkg::STATUS_W-1:0]       rsp_status,
   output logic [sbl_pkg::ENTRY_COUNT_W-1:0]  rsp_entry_count
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = CW + sbl_pkg::ENTRY_COUNT_W;
   localparam int VW = sbl_pkg::VALUE_W;

   logic [VW-1:0] mem [CAPACITY];
   logic [VW-1:0] rdata_ff;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [VW-1:0] val_ff, val_in;
   logic          op_ff, op_in;
   logic          found_ff, found_in;
   sbl_pkg::status_type stat_ff, stat_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [sbl_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [sbl_pkg::ENTRY_COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [VW-1:0] wr_data;
   logic [AW-1:0] rd_addr;
   logic [CW-1:0] ptr_dec;
   logic [CW-1:0] ptr_inc;
   logic [XW-1:0] count_wide;
   logic          ins_more;
   logic          del_hit;
   logic          del_last;

   assign ptr_dec    = ptr_ff - CW'(1);
   assign ptr_inc    = ptr_ff + CW'(1);
   assign count_wide = XW'(count_ff);
   assign ins_more   = (ptr_ff != '0) && (rdata_ff >= val_ff);
   assign del_hit    = found_ff || (rdata_ff == val_ff);
   assign del_last   = (ptr_inc == count_ff);
   assign rd_addr    = (op_ff == sbl_pkg::CMD_INSERT) ? ptr_dec[AW-1:0] : ptr_ff[AW-1:0];

   assign sts.full      = (count_ff == CW'(CAPACITY));
   assign sts.empty     = (count_ff == '0);
   assign sts.ins_more  = ins_more;
   assign sts.del_last  = del_last;
   assign sts.slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      val_in        = val_ff;
      op_in         = op_ff;
      found_in      = found_ff;
      stat_in       = stat_ff;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff[AW-1:0];
      wr_data       = val_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      if (cmd.load) begin
         op_in    = req_command;
         val_in   = req_item_value;
         found_in = 1'b0;
         if (req_command == sbl_pkg::CMD_INSERT) begin
            ptr_in  = count_ff;
            stat_in = sts.full ? sbl_pkg::ST_FULL : sbl_pkg::ST_INSERTED;
         end else begin
            ptr_in  = '0;
            stat_in = sts.empty ? sbl_pkg::ST_EMPTY : sbl_pkg::ST_NOT_FOUND;
         end
      end

      // walk down from the top, moving entries greater than or equal to the value up one slot
      if (cmd.ins_step) begin
         wr_en = 1'b1;
         if (ins_more) begin
            wr_data = rdata_ff;
            ptr_in  = ptr_dec;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end

      // walk up; after the match every entry moves down one slot
      if (cmd.del_step) begin
         found_in = del_hit;
         ptr_in   = ptr_inc;
         if (found_ff) begin
            wr_en   = 1'b1;
            wr_addr = ptr_dec[AW-1:0];
            wr_data = rdata_ff;
         end
         if (del_last && del_hit) begin
            count_in = count_ff - CW'(1);
            stat_in  = sbl_pkg::ST_REMOVED;
         end
      end

      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = stat_ff;
         rsp_count_in  = count_wide[sbl_pkg::ENTRY_COUNT_W-1:0];
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      val_ff        <= val_in;
      op_ff         <= op_in;
      found_ff      <= found_in;
      stat_ff       <= stat_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

// ----- hdl/sorted_byte_list_top.sv -----
// sorted list of bytes, ascending, duplicates allowed, up to CAPACITY entries
// request channel: req_valid / req_stall with req_command (0 insert, 1 delete)
//   and req_item_value; a word is taken when req_valid is high and req_stall low
// response channel: rsp_valid / rsp_stall with rsp_status and rsp_entry_count,
//   one response word per request word, in order
// insert goes in front of the first entry greater than or equal to the value
// delete removes the first entry equal to the value
// work, with n entries stored, from one accepted request to the next: the entry
//   memory has one read port with a registered output, so each visited entry
//   passes through a read state and then a check state
//   insert: visits from the top down through the entries greater or equal
//   delete: visits all n entries; full insert or empty delete: straight to done
// a new request is taken while the previous response still waits in the
//   output register; the next response then waits in the controller and
//   req_stall stays high until the output register frees
// rsp_stall holds the response word steady until it is taken
// reset empties the list at once and drops any pending response
module sorted_byte_list_top #(
   parameter int CAPACITY = sbl_pkg::CAPACITY_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_command,
   input  logic [sbl_pkg::VALUE_W-1:0]        req_item_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [sbl_pkg::STATUS_W-1:0]       rsp_status,
   output logic [sbl_pkg::ENTRY_COUNT_W-1:0]  rsp_entry_count
);

   sbl_pkg::cmd_type cmd;
   sbl_pkg::sts_type sts;

   sbl_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .sts         (sts),
      .cmd         (cmd),
      .req_stall   (req_stall)
   );

   sbl_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_command     (req_command),
      .req_item_value  (req_item_value),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

typedef struct {
   sbl_pkg::status_type        status;
   logic [sbl_pkg::ENTRY_COUNT_W-1:0] count;
} list_outcome_type;

class list_scoreboard;
   localparam int CNT_W = sbl_pkg::ENTRY_COUNT_W;

   int unsigned capacity;
   logic [sbl_pkg::VALUE_W-1:0] shadow_list[$];
   list_outcome_type pending_outcomes[$];
   int errors;

   function new(int unsigned cap);
      capacity = cap;
      errors = 0;
   endfunction

   task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   function int pending();
      return pending_outcomes.size();
   endfunction

   // apply one accepted request word to the shadow list and queue its outcome
   function void note_request(logic cmd, logic [sbl_pkg::VALUE_W-1:0] val);
      list_outcome_type o;
      int pos;
      pos = 0;
      if (cmd == sbl_pkg::CMD_INSERT) begin
         if (shadow_list.size() >= capacity) begin
            o.status = sbl_pkg::ST_FULL;
         end else begin
            while (pos < shadow_list.size() && shadow_list[pos] < val) pos++;
            shadow_list.insert(pos, val);
            o.status = sbl_pkg::ST_INSERTED;
         end
      end else if (shadow_list.size() == 0) begin
         o.status = sbl_pkg::ST_EMPTY;
      end else begin
         while (pos < shadow_list.size() && shadow_list[pos] != val) pos++;
         if (pos >= shadow_list.size()) begin
            o.status = sbl_pkg::ST_NOT_FOUND;
         end else begin
            shadow_list.delete(pos);
            o.status = sbl_pkg::ST_REMOVED;
         end
      end
      o.count = CNT_W'(shadow_list.size());
      pending_outcomes.push_back(o);
   endfunction

   task check_response(logic [sbl_pkg::STATUS_W-1:0] st,
                       logic [sbl_pkg::ENTRY_COUNT_W-1:0] cnt);
      list_outcome_type o;
      if (pending_outcomes.size() == 0) begin
         report($sformatf("response word with none outstanding (status %0d count %0d)",
                          st, cnt));
      end else begin
         o = pending_outcomes.pop_front();
         if (st !== o.status)
            report($sformatf("status %0d, expected %0d", st, o.status));
         if (cnt !== o.count)
            report($sformatf("entry count %0d, expected %0d", cnt, o.count));
      end
   endtask
endclass

module testbench;

   localparam int CAPACITY = sbl_pkg::CAPACITY_DEFAULT;
   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_WORDS = 1125;
   localparam int VW = sbl_pkg::VALUE_W;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_command = sbl_pkg::CMD_INSERT;
   logic [VW-1:0] req_item_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [sbl_pkg::STATUS_W-1:0] rsp_status;
   logic [sbl_pkg::ENTRY_COUNT_W-1:0] rsp_entry_count;

   logic quiet = 1'b0;
   int idle_cycles = 0;
   list_scoreboard sb = new(CAPACITY);

   sorted_byte_list_top #(.CAPACITY(CAPACITY)) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_item_value(req_item_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_entry_count(rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_word(input logic cmd, input logic [VW-1:0] val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_command = cmd;
      req_item_value = val;
      do @(posedge clock); while (req_stall);
      sb.note_request(cmd, val);
      @(negedge clock);
   endtask

   task automatic run_directed();
      send_word(sbl_pkg::CMD_DELETE, 8'h00);
      send_word(sbl_pkg::CMD_INSERT, 8'h00);
      send_word(sbl_pkg::CMD_INSERT, 8'hff);
      send_word(sbl_pkg::CMD_INSERT, 8'h80);
      send_word(sbl_pkg::CMD_INSERT, 8'h80);
      send_word(sbl_pkg::CMD_INSERT, 8'h7f);
      send_word(sbl_pkg::CMD_INSERT, 8'h01);
      send_word(sbl_pkg::CMD_DELETE, 8'h55);
      send_word(sbl_pkg::CMD_DELETE, 8'h80);
      send_word(sbl_pkg::CMD_DELETE, 8'h00);
      for (int i = 0; i < CAPACITY - 4; i++)
         send_word(sbl_pkg::CMD_INSERT, 8'(i * 23 + 5));
      send_word(sbl_pkg::CMD_INSERT, 8'hff);
      send_word(sbl_pkg::CMD_DELETE, 8'hff);
      send_word(sbl_pkg::CMD_DELETE, 8'haa);
   endtask

   task automatic run_random(int total);
      int sent;
      int bias;
      int len;
      int r;
      logic cmd;
      logic [VW-1:0] val;
      sent = 0;
      while (sent < total) begin
         case ($urandom_range(0, 3))
            0: bias = 15;
            1: bias = 50;
            2: bias = 85;
            default: bias = 97;
         endcase
         len = $urandom_range(20, 80);
         quiet = ($urandom_range(0, 4) == 0);
         for (int i = 0; i < len && sent < total; i++) begin
            cmd = ($urandom_range(0, 99) < bias) ? sbl_pkg::CMD_INSERT : sbl_pkg::CMD_DELETE;
            r = $urandom_range(0, 99);
            if (cmd == sbl_pkg::CMD_DELETE && sb.shadow_list.size() != 0 && r < 70)
               val = sb.shadow_list[$urandom_range(0, sb.shadow_list.size() - 1)];
            else if (r < 85)
               val = VW'($urandom_range(0, 255));
            else if (r < 93)
               val = VW'($urandom_range(0, 3));
            else
               val = VW'($urandom_range(252, 255));
            send_word(cmd, val);
            sent++;
         end
      end
      quiet = 1'b0;
   endtask

   // response side back-pressure
   initial begin
      int n;
      int r;
      forever begin
         r = $urandom_range(0, 99);
         if (quiet || r < 50) n = 0;
         else if (r < 90) n = $urandom_range(1, 4);
         else n = $urandom_range(10, 40);
         if (n > 0) begin
            rsp_stall = 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_status, rsp_entry_count);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      run_directed();
      run_random(RANDOM_WORDS);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
